/* rtl/kspa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kspa_pkg
// Shared types and constants of the keyed slot pool allocator.
// ----------------------------------------------------------------------------
package kspa_pkg;

    // Stream word layouts
    localparam int S_TDATA_W  = 16;   // track, step, slot
    localparam int S_TUSER_W  = 2;    // command
    localparam int M_TDATA_W  = 112;  // index, status, free count, three counters

    // Field widths
    localparam int TRACK_W    = 4;
    localparam int STEP_W     = 6;
    localparam int SLOT_F_W   = 6;
    localparam int INDEX_F_W  = 6;
    localparam int FREE_F_W   = 7;
    localparam int CNT_W      = 32;
    localparam int KEY_W      = TRACK_W + STEP_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TLIM_W     = 5;
    localparam int SLIM_W     = 7;
    localparam logic [TLIM_W-1:0] TLIM_RESET = 5'd8;
    localparam logic [SLIM_W-1:0] SLIM_RESET = 7'd32;

    // Register index, taken from paddr[2]
    localparam logic REG_TRACK_LIMIT = 1'b0;
    localparam logic REG_STEP_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_DEALLOC = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_NEW       = 3'd0,
        STAT_EXISTING  = 3'd1,
        STAT_BAD_POS   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_DONE      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_PICK,
        S_LAST,
        S_COMMIT,
        S_EMIT
    } state_t;

endpackage

/* rtl/keyed_slot_pool_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_pool_allocator_core
// Slot pool keyed by (track, step) with a compact free list in memory.
// ----------------------------------------------------------------------------
// Flow: deallocate, clear and rejected commands go straight from S_DECIDE
//   to S_EMIT; a find or duplicate allocate scans the key memory from slot 0,
//   one key-memory read per cycle, up to the hit or the last slot, and a new
//   grant then passes S_PICK, S_LAST and S_COMMIT on its way to S_EMIT.
// Throughput: one command at a time; the next word is taken once the result
//   sits in the output register.
// Reset: aresetn synchronous, active low. Busy and free-list valid bits clear
//   at once, so no clearing pass; limits return to 8 and 32, counters to zero.
module keyed_slot_pool_allocator_core #(
    parameter int POOL_SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kspa_pkg::S_TDATA_W-1:0]   s_tdata,  // track[3:0], step[9:4], slot[15:10]
    input  logic [kspa_pkg::S_TUSER_W-1:0]   s_tuser,  // command[1:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kspa_pkg::M_TDATA_W-1:0]   m_tdata,  // slot_index[5:0], status[8:6],
                                                       // free_slots[15:9], alloc_total[47:16],
                                                       // dealloc_total[79:48], fail_total[111:80]
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kspa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [kspa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [kspa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import kspa_pkg::*;

    localparam int SLOT_W    = $clog2(POOL_SLOTS);
    localparam int FC_W      = $clog2(POOL_SLOTS + 1);
    localparam int MODC_W    = $clog2(SLOT_W + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);
    localparam logic [FC_W-1:0]   FC_FULL   = FC_W'(POOL_SLOTS);
    localparam logic [MODC_W-1:0] MOD_STEPS = MODC_W'(SLOT_W);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;

    cmd_t                   cmd_reg, cmd_next;
    logic [TRACK_W-1:0]     track_reg, track_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SLOT_F_W-1:0]    slot_reg, slot_next;

    logic [TLIM_W-1:0]      tlim_reg, tlim_next;
    logic [SLIM_W-1:0]      slim_reg, slim_next;

    logic [POOL_SLOTS-1:0]  busy_reg, busy_next;      // valid bits of the key memory
    logic [POOL_SLOTS-1:0]  flv_reg, flv_next;        // free-list entry written since clear
    logic [FC_W-1:0]        fc_reg, fc_next;
    logic [SLOT_W-1:0]      hint_reg, hint_next;
    logic [CNT_W-1:0]       alloc_cnt_reg, alloc_cnt_next;
    logic [CNT_W-1:0]       dealloc_cnt_reg, dealloc_cnt_next;
    logic [CNT_W-1:0]       fail_cnt_reg, fail_cnt_next;

    // scan pipeline
    logic [SLOT_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [SLOT_W-1:0]      cmp_addr_reg, cmp_addr_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   busy_rd_reg, busy_rd_next;

    // hint % free_count, restoring, one hint bit per cycle
    logic [MODC_W-1:0]      mod_cnt_reg, mod_cnt_next;
    logic [FC_W-1:0]        rem_reg, rem_next;
    logic [SLOT_W-1:0]      hint_sh_reg, hint_sh_next;

    logic [SLOT_W-1:0]      pick_reg, pick_next;
    logic [SLOT_W-1:0]      grant_reg, grant_next;
    logic [SLOT_W-1:0]      res_idx_reg, res_idx_next;
    status_t                res_stat_reg, res_stat_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Memories: key store and free list, registered read
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]       key_mem [POOL_SLOTS];
    logic [KEY_W-1:0]       key_rd_reg;
    logic                   key_we;
    logic [SLOT_W-1:0]      key_waddr;
    logic [KEY_W-1:0]       key_wdata;

    logic [SLOT_W-1:0]      fl_mem [POOL_SLOTS];
    logic [SLOT_W-1:0]      fl_rd_reg;
    logic                   fl_rd_vld_reg;
    logic [SLOT_W-1:0]      fl_raddr_reg;
    logic [SLOT_W-1:0]      fl_raddr;
    logic                   fl_we;
    logic [SLOT_W-1:0]      fl_waddr;
    logic [SLOT_W-1:0]      fl_wdata;
    logic [SLOT_W-1:0]      fl_eff;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[scan_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (fl_we) begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        fl_rd_reg     <= fl_mem[fl_raddr];
        fl_rd_vld_reg <= flv_reg[fl_raddr];
        fl_raddr_reg  <= fl_raddr;
    end

    // never-written entries read as identity
    assign fl_eff = fl_rd_vld_reg ? fl_rd_reg : fl_raddr_reg;

    // ------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------
    logic                   in_acc;
    logic                   pos_ok;
    logic [8:0]             slot_wide;
    logic [SLOT_W-1:0]      slot_idx;
    logic                   dealloc_ok;
    logic                   hit;
    logic                   scan_miss;
    logic                   emit_load;
    logic [FC_W-1:0]        fc_m1;
    logic [FC_W:0]          mod_t;
    logic [FC_W:0]          mod_sub;
    logic                   cfg_wr;

    assign in_acc     = s_tvalid && s_tready;
    assign pos_ok     = ({1'b0, track_reg} < tlim_reg) && ({1'b0, step_reg} < slim_reg);
    assign slot_wide  = 9'(slot_reg);
    assign slot_idx   = slot_wide[SLOT_W-1:0];
    assign dealloc_ok = (slot_wide < 9'(POOL_SLOTS)) && busy_reg[slot_idx];
    assign hit        = cmp_valid_reg && busy_rd_reg && (key_rd_reg == {track_reg, step_reg});
    assign scan_miss  = cmp_valid_reg && !hit && (cmp_addr_reg == LAST_SLOT);
    assign emit_load  = !m_tvalid_reg || m_tready;
    assign fc_m1      = fc_reg - FC_W'(1);
    assign mod_t      = {rem_reg, hint_sh_reg[SLOT_W-1]};
    assign mod_sub    = mod_t - {1'b0, fc_reg};
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_STEP_LIMIT) ? CFG_DATA_W'(slim_reg)
                                                     : CFG_DATA_W'(tlim_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (pos_ok && fc_reg != '0) state_next = S_SCAN;
                        else                        state_next = S_EMIT;
                    end
                    CMD_FIND: begin
                        if (pos_ok) state_next = S_SCAN;
                        else        state_next = S_EMIT;
                    end
                    default: state_next = S_EMIT;
                endcase
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = S_EMIT;
                end else if (scan_miss) begin
                    state_next = (cmd_reg == CMD_FIND) ? S_EMIT : S_PICK;
                end
            end
            S_PICK:   state_next = S_LAST;
            S_LAST:   state_next = S_COMMIT;
            S_COMMIT: state_next = S_EMIT;
            S_EMIT: begin
                if (emit_load) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        cmd_next         = cmd_reg;
        track_next       = track_reg;
        step_next        = step_reg;
        slot_next        = slot_reg;
        tlim_next        = tlim_reg;
        slim_next        = slim_reg;
        busy_next        = busy_reg;
        flv_next         = flv_reg;
        fc_next          = fc_reg;
        hint_next        = hint_reg;
        alloc_cnt_next   = alloc_cnt_reg;
        dealloc_cnt_next = dealloc_cnt_reg;
        fail_cnt_next    = fail_cnt_reg;
        scan_addr_next   = scan_addr_reg;
        cmp_addr_next    = cmp_addr_reg;
        cmp_valid_next   = cmp_valid_reg;
        busy_rd_next     = busy_rd_reg;
        mod_cnt_next     = mod_cnt_reg;
        rem_next         = rem_reg;
        hint_sh_next     = hint_sh_reg;
        pick_next        = pick_reg;
        grant_next       = grant_reg;
        res_idx_next     = res_idx_reg;
        res_stat_next    = res_stat_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        key_we           = 1'b0;
        key_waddr        = grant_reg;
        key_wdata        = {track_reg, step_reg};
        fl_we            = 1'b0;
        fl_waddr         = pick_reg;
        fl_wdata         = fl_eff;
        fl_raddr         = '0;

        if (cfg_wr) begin
            if (paddr[2] == REG_STEP_LIMIT) slim_next = pwdata[SLIM_W-1:0];
            else                            tlim_next = pwdata[TLIM_W-1:0];
        end

        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    cmd_next       = cmd_t'(s_tuser[1:0]);
                    track_next     = s_tdata[3:0];
                    step_next      = s_tdata[9:4];
                    slot_next      = s_tdata[15:10];
                    scan_addr_next = '0;
                    cmp_valid_next = 1'b0;
                    mod_cnt_next   = MOD_STEPS;
                    rem_next       = '0;
                    hint_sh_next   = hint_reg;
                end
            end
            S_DECIDE: begin
                res_idx_next  = '0;
                res_stat_next = STAT_DONE;
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (!pos_ok) begin
                            fail_cnt_next = fail_cnt_reg + CNT_W'(1);
                            res_stat_next = STAT_BAD_POS;
                        end else if (fc_reg == '0) begin
                            // full is checked ahead of the lookup
                            fail_cnt_next = fail_cnt_reg + CNT_W'(1);
                            res_stat_next = STAT_FULL;
                        end
                    end
                    CMD_DEALLOC: begin
                        if (dealloc_ok) begin
                            busy_next[slot_idx] = 1'b0;
                            if (fc_reg < FC_FULL) begin
                                fl_we              = 1'b1;
                                fl_waddr           = fc_reg[SLOT_W-1:0];
                                fl_wdata           = slot_idx;
                                flv_next[fl_waddr] = 1'b1;
                                fc_next            = fc_reg + FC_W'(1);
                            end
                            dealloc_cnt_next = dealloc_cnt_reg + CNT_W'(1);
                        end
                    end
                    CMD_FIND: begin
                        if (!pos_ok) res_stat_next = STAT_NOT_FOUND;
                    end
                    default: begin
                        busy_next = '0;
                        flv_next  = '0;
                        fc_next   = FC_FULL;
                        hint_next = '0;
                    end
                endcase
            end
            S_SCAN: begin
                // read issued at scan_addr, compared in the cycle after
                busy_rd_next   = busy_reg[scan_addr_reg];
                cmp_addr_next  = scan_addr_reg;
                cmp_valid_next = 1'b1;
                if (scan_addr_reg != LAST_SLOT) scan_addr_next = scan_addr_reg + SLOT_W'(1);
                if (mod_cnt_reg != '0) begin
                    rem_next     = mod_sub[FC_W] ? mod_t[FC_W-1:0] : mod_sub[FC_W-1:0];
                    hint_sh_next = hint_sh_reg << 1;
                    mod_cnt_next = mod_cnt_reg - MODC_W'(1);
                end
                if (hit) begin
                    res_idx_next  = cmp_addr_reg;
                    res_stat_next = STAT_EXISTING;
                end else if (scan_miss) begin
                    res_stat_next = STAT_NOT_FOUND;
                end
            end
            S_PICK: begin
                fl_raddr  = rem_reg[SLOT_W-1:0];
                pick_next = rem_reg[SLOT_W-1:0];
            end
            S_LAST: begin
                grant_next = fl_eff;
                fl_raddr   = fc_m1[SLOT_W-1:0];
            end
            S_COMMIT: begin
                // last free entry fills the hole at pick
                fl_we               = 1'b1;
                fl_waddr            = pick_reg;
                fl_wdata            = fl_eff;
                flv_next[pick_reg]  = 1'b1;
                fc_next             = fc_m1;
                hint_next           = (hint_reg == LAST_SLOT) ? '0 : hint_reg + SLOT_W'(1);
                key_we              = 1'b1;
                busy_next[grant_reg] = 1'b1;
                alloc_cnt_next      = alloc_cnt_reg + CNT_W'(1);
                res_idx_next        = grant_reg;
                res_stat_next       = STAT_NEW;
            end
            S_EMIT: begin
                if (emit_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {fail_cnt_reg, dealloc_cnt_reg, alloc_cnt_reg,
                                     FREE_F_W'(fc_reg), res_stat_reg,
                                     INDEX_F_W'(res_idx_reg)};
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            tlim_reg        <= TLIM_RESET;
            slim_reg        <= SLIM_RESET;
            busy_reg        <= '0;
            flv_reg         <= '0;
            fc_reg          <= FC_FULL;
            hint_reg        <= '0;
            alloc_cnt_reg   <= '0;
            dealloc_cnt_reg <= '0;
            fail_cnt_reg    <= '0;
            cmp_valid_reg   <= 1'b0;
            mod_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tlim_reg        <= tlim_next;
            slim_reg        <= slim_next;
            busy_reg        <= busy_next;
            flv_reg         <= flv_next;
            fc_reg          <= fc_next;
            hint_reg        <= hint_next;
            alloc_cnt_reg   <= alloc_cnt_next;
            dealloc_cnt_reg <= dealloc_cnt_next;
            fail_cnt_reg    <= fail_cnt_next;
            cmp_valid_reg   <= cmp_valid_next;
            mod_cnt_reg     <= mod_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        track_reg     <= track_next;
        step_reg      <= step_next;
        slot_reg      <= slot_next;
        scan_addr_reg <= scan_addr_next;
        cmp_addr_reg  <= cmp_addr_next;
        busy_rd_reg   <= busy_rd_next;
        rem_reg       <= rem_next;
        hint_sh_reg   <= hint_sh_next;
        pick_reg      <= pick_next;
        grant_reg     <= grant_next;
        res_idx_reg   <= res_idx_next;
        res_stat_reg  <= res_stat_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule

/* rtl/kspa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kspa_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module kspa_checker #(
    parameter int POOL_SLOTS = 64
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [kspa_pkg::M_TDATA_W-1:0] m_tdata
);
    import kspa_pkg::*;

    logic [2:0] stat;
    assign stat = m_tdata[8:6];

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one command in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

    // failures carry slot zero
    a_fail_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == STAT_BAD_POS || stat == STAT_FULL || stat == STAT_NOT_FOUND)
        |-> m_tdata[5:0] == '0)
        else $error("failed command reports a slot");

    // free count never exceeds the pool
    a_free_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[15:9]) <= 32'(POOL_SLOTS))
        else $error("free count above pool size");

    // a fresh grant leaves at least one slot taken
    a_new_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat == STAT_NEW |-> 32'(m_tdata[15:9]) < 32'(POOL_SLOTS))
        else $error("new grant with pool still empty");

endmodule

bind keyed_slot_pool_allocator_core kspa_checker #(.POOL_SLOTS(POOL_SLOTS)) u_kspa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/keyed_slot_pool_allocator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_pool_allocator_core_tb
// Self-checking bench for the slot pool allocator. Command words are queued by
// the stimulus process and streamed in by a clocked driver. An in-bench copy
// of the allocator predicts each result word when its command is accepted.
// A clocked monitor compares every result word field by field. Phases sweep
// the track and step limits and the idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module keyed_slot_pool_allocator_core_tb;
    import kspa_pkg::*;

    localparam int POOL        = 64;
    localparam int HALF_CYCLE  = 10;
    localparam int RESET_CYC   = 8;
    localparam int STALL_LIMIT = 4000;   // quiet cycles before giving up
    localparam int TAIL_CYCLES = 100;    // longer than the slowest command
    localparam int LONG_HOLD   = 400;    // receiver back-pressure burst
    localparam int RECENT_KEYS = 32;

    typedef struct {
        cmd_t                cmd;
        logic [TRACK_W-1:0]  track;
        logic [STEP_W-1:0]   step;
        logic [SLOT_F_W-1:0] slot;
    } pool_cmd_t;

    typedef struct {
        logic [INDEX_F_W-1:0] index;
        status_t              status;
        logic [FREE_F_W-1:0]  free_slots;
        logic [CNT_W-1:0]     allocs;
        logic [CNT_W-1:0]     releases;
        logic [CNT_W-1:0]     fails;
    } pool_result_t;

    typedef struct {
        logic [TRACK_W-1:0] track;
        logic [STEP_W-1:0]  step;
    } key_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // track[3:0], step[9:4], slot[15:10]
    logic [S_TUSER_W-1:0]  s_tuser  = '0;  // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // slot_index, status, free_slots,
                                           // alloc, dealloc, fail totals
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    keyed_slot_pool_allocator_core #(
        .POOL_SLOTS (POOL)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_CYCLE) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    pool_cmd_t    cmd_backlog[$];    // words waiting for the driver
    pool_result_t outcome_q[$];      // predicted results, oldest first
    key_t         recent[$];         // keys recently allocated, for hits
    pool_result_t want;
    int           err_count     = 0;
    int           quiet_cycles  = 0;
    int           snd_idle_pct  = 0;
    int           rcv_stall_pct = 0;
    bit           rx_hold_req   = 1'b0;
    bit           hold_taken    = 1'b0;
    int           hold_left     = 0;

    // Allocator copy: busy map, keys, compact free list, round-robin hint
    bit                   slot_used  [POOL];
    logic [TRACK_W-1:0]   used_track [POOL];
    logic [STEP_W-1:0]    used_step  [POOL];
    logic [INDEX_F_W-1:0] free_stack [POOL];
    int                   free_cnt;
    int                   rr_hint;
    logic [CNT_W-1:0]     grant_cnt;
    logic [CNT_W-1:0]     release_cnt;
    logic [CNT_W-1:0]     reject_cnt;
    int                   track_lim;
    int                   step_lim;

    function automatic void empty_model();
        for (int i = 0; i < POOL; i++) begin
            slot_used[i]  = 1'b0;
            used_track[i] = '0;
            used_step[i]  = '0;
            free_stack[i] = INDEX_F_W'(i);
        end
        free_cnt = POOL;
        rr_hint  = 0;
    endfunction

    // POOL when no busy slot holds the key
    function automatic int find_key(logic [TRACK_W-1:0] trk, logic [STEP_W-1:0] stp);
        for (int i = 0; i < POOL; i++) begin
            if (slot_used[i] && used_track[i] == trk && used_step[i] == stp)
                return i;
        end
        return POOL;
    endfunction

    // Applies one command to the allocator copy and returns its result word
    function automatic pool_result_t allocator_outcome(pool_cmd_t c);
        pool_result_t r;
        int           hit;
        int           pick;
        bit           pos_ok;
        r.index  = '0;
        r.status = STAT_DONE;
        pos_ok   = (c.track < track_lim) && (c.step < step_lim);
        case (c.cmd)
            CMD_ALLOC: begin
                if (!pos_ok) begin
                    reject_cnt++;
                    r.status = STAT_BAD_POS;
                end else if (free_cnt == 0) begin
                    // full pool fails even for a key already held
                    reject_cnt++;
                    r.status = STAT_FULL;
                end else begin
                    hit = find_key(c.track, c.step);
                    if (hit < POOL) begin
                        r.index  = INDEX_F_W'(hit);
                        r.status = STAT_EXISTING;
                    end else begin
                        pick               = rr_hint % free_cnt;
                        r.index            = free_stack[pick];
                        free_stack[pick]   = free_stack[free_cnt-1];
                        free_cnt--;
                        rr_hint            = (rr_hint + 1) % POOL;
                        slot_used[r.index]  = 1'b1;
                        used_track[r.index] = c.track;
                        used_step[r.index]  = c.step;
                        grant_cnt++;
                        r.status = STAT_NEW;
                    end
                end
            end
            CMD_DEALLOC: begin
                // unused slot: ignored, still reports done
                if (slot_used[c.slot]) begin
                    slot_used[c.slot]  = 1'b0;
                    used_track[c.slot] = '0;
                    used_step[c.slot]  = '0;
                    if (free_cnt < POOL) begin
                        free_stack[free_cnt] = c.slot;
                        free_cnt++;
                    end
                    release_cnt++;
                end
            end
            CMD_FIND: begin
                hit = pos_ok ? find_key(c.track, c.step) : POOL;
                if (hit < POOL) begin
                    r.index  = INDEX_F_W'(hit);
                    r.status = STAT_EXISTING;
                end else begin
                    r.status = STAT_NOT_FOUND;
                end
            end
            default: empty_model();   // clear keeps the counters
        endcase
        r.free_slots = FREE_F_W'(free_cnt);
        r.allocs     = grant_cnt;
        r.releases   = release_cnt;
        r.fails      = reject_cnt;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] got);
        if (exp_v !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the backlog head, holds it until accepted.
    // The result is predicted at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit offering;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(allocator_outcome(cmd_backlog[0]));
                void'(cmd_backlog.pop_front());
                offering = 1'b0;
            end
            if (!offering) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cmd_backlog[0].slot, cmd_backlog[0].step,
                                 cmd_backlog[0].track};
                    s_tuser  <= cmd_backlog[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver ready: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result word with nothing expected, got %h", $time, m_tdata);
                err_count++;
            end else begin
                want = outcome_q.pop_front();
                check_field("slot_index",    want.index,      m_tdata[5:0]);
                check_field("status",        want.status,     m_tdata[8:6]);
                check_field("free_slots",    want.free_slots, m_tdata[15:9]);
                check_field("alloc_total",   want.allocs,     m_tdata[47:16]);
                check_field("dealloc_total", want.releases,   m_tdata[79:48]);
                check_field("fail_total",    want.fails,      m_tdata[111:80]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no word moving on either stream for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_word(cmd_t cmd, int trk, int stp, int slt);
        pool_cmd_t w;
        w.cmd   = cmd;
        w.track = TRACK_W'(trk);
        w.step  = STEP_W'(stp);
        w.slot  = SLOT_F_W'(slt);
        cmd_backlog.push_back(w);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() > 0 || outcome_q.size() > 0)
            @(posedge aclk);
    endtask

    // Two-phase write; upper data bits carry junk the register must drop
    task automatic write_limit(logic reg_sel, int value);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = $urandom();
        if (reg_sel == REG_TRACK_LIMIT)
            wdata[TLIM_W-1:0] = TLIM_W'(value);
        else
            wdata[SLIM_W-1:0] = SLIM_W'(value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TRACK_LIMIT)
            track_lim = int'(wdata[TLIM_W-1:0]);
        else
            step_lim = int'(wdata[SLIM_W-1:0]);
    endtask

    // Mostly in-limit keys, a share of them reused so that duplicates and
    // find hits happen; a few words keep fully random fields as noise.
    task automatic queue_random(int count, int a_pct, int d_pct, int f_pct);
        pool_cmd_t w;
        key_t      k;
        int        r;
        int        hi_track;
        int        hi_step;
        hi_track = (track_lim == 0 || track_lim > 16) ? 15 : track_lim - 1;
        hi_step  = (step_lim == 0 || step_lim > 64) ? 63 : step_lim - 1;
        for (int i = 0; i < count; i++) begin
            w.track = TRACK_W'($urandom_range(15));
            w.step  = STEP_W'($urandom_range(63));
            w.slot  = SLOT_F_W'($urandom_range(63));
            r = $urandom_range(99);
            if (r < a_pct)
                w.cmd = CMD_ALLOC;
            else if (r < a_pct + d_pct)
                w.cmd = CMD_DEALLOC;
            else if (r < a_pct + d_pct + f_pct)
                w.cmd = CMD_FIND;
            else
                w.cmd = CMD_CLEAR;
            if ((w.cmd == CMD_ALLOC || w.cmd == CMD_FIND) && $urandom_range(99) >= 8) begin
                if (recent.size() > 0 && $urandom_range(99) < 30) begin
                    k = recent[$urandom_range(recent.size() - 1)];
                end else begin
                    k.track = TRACK_W'($urandom_range(hi_track));
                    k.step  = STEP_W'($urandom_range(hi_step));
                end
                w.track = k.track;
                w.step  = k.step;
            end
            if (w.cmd == CMD_ALLOC) begin
                k.track = w.track;
                k.step  = w.step;
                recent.push_back(k);
                if (recent.size() > RECENT_KEYS)
                    void'(recent.pop_front());
            end
            cmd_backlog.push_back(w);
        end
    endtask

    // One phase: new limits while idle, then a burst, then full drain
    task automatic run_phase(int tl, int sl, int snd, int rcv, int count,
                             int a_pct, int d_pct, int f_pct, bit long_hold);
        write_limit(REG_TRACK_LIMIT, tl);
        write_limit(REG_STEP_LIMIT, sl);
        snd_idle_pct  <= snd;
        rcv_stall_pct <= rcv;
        queue_random(count, a_pct, d_pct, f_pct);
        if (long_hold)
            rx_hold_req <= 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        empty_model();
        grant_cnt   = '0;
        release_cnt = '0;
        reject_cnt  = '0;
        track_lim   = int'(TLIM_RESET);
        step_lim    = int'(SLIM_RESET);
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass at the reset limits (8 tracks, 32 steps)
        add_word(CMD_ALLOC,   0,  0, 63);   // first grant
        add_word(CMD_ALLOC,   7, 31,  0);   // top of the valid range
        add_word(CMD_ALLOC,   7, 31, 63);   // duplicate key
        add_word(CMD_ALLOC,   8,  0,  0);   // track just over the limit
        add_word(CMD_ALLOC,   0, 32,  0);   // step just over the limit
        add_word(CMD_ALLOC,  15, 63, 63);   // both fields at their maximum
        add_word(CMD_FIND,    7, 31,  0);   // hit
        add_word(CMD_FIND,    1,  1, 63);   // miss
        add_word(CMD_FIND,    8, 31,  0);   // bad position reads as not found
        add_word(CMD_DEALLOC, 15, 63,  0);  // release slot 0
        add_word(CMD_DEALLOC, 0,  0,  0);   // slot 0 again, now unused
        add_word(CMD_DEALLOC, 0,  0, 63);   // never used
        add_word(CMD_FIND,    0,  0,  0);   // released key gone
        add_word(CMD_ALLOC,   0,  0,  0);   // re-grant from the free list
        add_word(CMD_ALLOC,   3,  5, 42);
        add_word(CMD_CLEAR,  15, 63, 63);   // counters survive
        add_word(CMD_FIND,    7, 31,  0);   // gone after clear
        add_word(CMD_DEALLOC, 0,  0,  1);   // unused after clear
        add_word(CMD_ALLOC,   3,  5,  0);
        add_word(CMD_ALLOC,   5, 17, 21);
        add_word(CMD_FIND,    3,  5, 63);
        add_word(CMD_FIND,    5, 17,  0);
        add_word(CMD_DEALLOC, 10, 42, 0);
        add_word(CMD_CLEAR,   0,  0,  0);
        wait_drained();

        // limits at max, no idling, allocate-heavy without clears: fills the pool
        run_phase(16, 64,  0,  0, 200, 85,  5, 10, 1'b0);
        // minimum limits: a single valid key; sender idles
        run_phase( 1,  1, 73,  0,  80, 50, 20, 25, 1'b0);
        // zero limits: every position bad; receiver stalls
        run_phase( 0,  0,  0, 73,  50, 60, 10, 30, 1'b0);
        // limits above the field ranges accept everything; both idle lightly
        run_phase(31, 127, 21, 21, 200, 55, 25, 15, 1'b0);
        // long receiver hold while words keep coming, input must back up
        run_phase( 5, 20,  0,  0, 150, 60, 20, 15, 1'b1);
        // refill at max limits under receiver stalls
        run_phase(16, 64,  0, 73, 200, 80,  8, 12, 1'b0);
        run_phase( 3, 10, 21, 21, 100, 45, 25, 25, 1'b0);

        // let any stray result word show up
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/kspa_pkg.sv
rtl/keyed_slot_pool_allocator_core.sv
rtl/kspa_checker.sv
dv/keyed_slot_pool_allocator_core_tb.sv
